// ----- rtl/core/ssym_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssym_pkg: shared types and constants of the scoped symbol table
// Action, status, kind and type codes, cell control word, type sizes.
// ---------------------------------------------------------------------------
package ssym_pkg;

  localparam int NAME_W   = 64;
  localparam int TYPE_W   = 4;
  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 14;
  localparam int STATUS_W = 3;
  localparam int ACTION_W = 2;

  localparam logic [ADDR_W-1:0] ADDR_MAX = 14'd16383;

  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_FUNCTION = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SCOPE_OVF = 3'd5;

  localparam logic [TYPE_W-1:0] TYPE_UNKNOWN_MIN = 4'd8;

  // Per-cycle move of every cell in the row
  typedef struct packed {
    logic take_prev;  // shift towards the bottom (push)
    logic take_next;  // shift towards the top (pop or rotate)
  } cell_ctl_t;

  // Storage size in bytes of a known type code (str is 80)
  function automatic logic [6:0] type_size(input logic [TYPE_W-1:0] t);
    logic [6:0] s;
    case (t)
      4'd0:    s = 7'd1;
      4'd1:    s = 7'd4;
      4'd2:    s = 7'd4;
      4'd3:    s = 7'd4;
      4'd4:    s = 7'd0;
      4'd5:    s = 7'd80;
      4'd6:    s = 7'd2;
      4'd7:    s = 7'd1;
      default: s = 7'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/scoped_symbol_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// scoped_symbol_table: stack-ordered symbol table with scope tracking
// Flow: an add passes S_ADD then S_OUT; a lookup turns the cell ring once
//   round in S_LOOK, then S_OUT; a delete pops in S_DEL, then S_OUT; a
//   rejected, empty-table or ignored word goes straight to S_OUT.
// Throughput: one word at a time; in_tready is high only in S_IDLE, so a word
//   holds the input until its result leaves S_OUT; the ring of entry cells
//   turns one place per cycle past the top; a stalled result holds off.
// Reset: synchronous, active low; clears count, scope and counter valid bits.
// ---------------------------------------------------------------------------
module scoped_symbol_table #(
  parameter int TABLE_DEPTH = 128,
  parameter int SCOPE_DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [71:0] in_tdata,   // name_key[63:0], type_code[67:64], kind_code[69:68], zero
  input  wire  [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata,  // entry_index[6:0], entry_type[10:7], entry_kind[12:11],
                                  // entry_scope[18:13], entry_address[32:19],
                                  // entry_count[40:33], scope_now[46:41], zero
  output logic [2:0]  out_tuser   // status
);
  import ssym_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int FILL_W  = $clog2(TABLE_DEPTH + 1);
  localparam int SCOPE_W = $clog2(SCOPE_DEPTH);
  // Entry word: address, scope, kind, type, name from the lowest bit up
  localparam int SC_LO   = ADDR_W;
  localparam int KD_LO   = SC_LO + SCOPE_W;
  localparam int TY_LO   = KD_LO + KIND_W;
  localparam int NM_LO   = TY_LO + TYPE_W;
  localparam int ENTRY_W = NM_LO + NAME_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_LOOK = 5'b00100,
    S_DEL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Latched input word
  logic [NAME_W-1:0] key_r;
  logic [TYPE_W-1:0] typ_r;
  logic [KIND_W-1:0] knd_r;

  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [SCOPE_W-1:0] scope_r, scope_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic               found_r, found_nxt;

  // Pending result
  logic [STATUS_W-1:0] rs_status_r, rs_status_nxt;
  logic [IDX_W-1:0]    rs_idx_r, rs_idx_nxt;
  logic [TYPE_W-1:0]   rs_type_r, rs_type_nxt;
  logic [KIND_W-1:0]   rs_kind_r, rs_kind_nxt;
  logic [SCOPE_W-1:0]  rs_scope_r, rs_scope_nxt;
  logic [ADDR_W-1:0]   rs_addr_r, rs_addr_nxt;

  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic [2:0]  out_user_r;

  // Per-scope address counters: memory plus a valid bit per scope
  logic [ADDR_W-1:0]      addr_mem [SCOPE_DEPTH];
  logic [ADDR_W-1:0]      rd_r;
  logic [SCOPE_DEPTH-1:0] sv_r, sv_nxt;
  logic                   rv_r;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_wdata;

  // Cell row; cell 0 is the top of stack
  cell_ctl_t          ctl;
  logic [ENTRY_W-1:0] cell_q [TABLE_DEPTH];
  logic [ENTRY_W-1:0] new_entry;

  logic               accept;
  logic [ADDR_W-1:0]  base_addr;
  logic [ADDR_W:0]    sum_addr;
  logic [IDX_W-1:0]   walk_idx;
  logic [SCOPE_W-1:0] top_scope;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign base_addr = rv_r ? rd_r : '0;
  assign sum_addr  = {1'b0, base_addr} + {{(ADDR_W - 6){1'b0}}, type_size(typ_r)};
  assign top_scope = cell_q[0][SC_LO +: SCOPE_W];
  assign walk_idx  = IDX_W'(fill_r - FILL_W'(1) - FILL_W'(cnt_r));
  assign new_entry = {key_r, typ_r, knd_r, scope_r, base_addr};
  assign mem_wdata = sum_addr[ADDR_W] ? ADDR_MAX : sum_addr[ADDR_W-1:0];

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      ssym_cell #(.ENTRY_W(ENTRY_W)) u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .prev_i ((g == 0) ? new_entry : cell_q[(g + TABLE_DEPTH - 1) % TABLE_DEPTH]),
        .next_i (cell_q[(g + 1) % TABLE_DEPTH]),
        .q_o    (cell_q[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    scope_nxt     = scope_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    sv_nxt        = sv_r;
    rs_status_nxt = rs_status_r;
    rs_idx_nxt    = rs_idx_r;
    rs_type_nxt   = rs_type_r;
    rs_kind_nxt   = rs_kind_r;
    rs_scope_nxt  = rs_scope_r;
    rs_addr_nxt   = rs_addr_r;
    ctl           = '0;
    mem_we        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          rs_status_nxt = ST_OK;
          rs_idx_nxt    = '0;
          rs_type_nxt   = '0;
          rs_kind_nxt   = '0;
          rs_scope_nxt  = '0;
          rs_addr_nxt   = '0;
          found_nxt     = 1'b0;
          cnt_nxt       = '0;
          unique case (in_tuser)
            ACT_ADD: begin
              if (fill_r == FILL_W'(TABLE_DEPTH)) begin
                rs_status_nxt = ST_FULL;
                state_nxt     = S_OUT;
              end else if (in_tdata[69:68] == KIND_FUNCTION &&
                           scope_r == SCOPE_W'(SCOPE_DEPTH - 1)) begin
                rs_status_nxt = ST_SCOPE_OVF;
                state_nxt     = S_OUT;
              end else begin
                state_nxt = S_ADD;
              end
            end
            ACT_LOOKUP: begin
              rs_status_nxt = ST_NOT_FOUND;
              state_nxt     = S_LOOK;
            end
            ACT_DELETE: begin
              if (fill_r == '0) begin
                rs_status_nxt = ST_EMPTY;
                state_nxt     = S_OUT;
              end else begin
                state_nxt = S_DEL;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_ADD: begin
        // Push the new entry; advance the scope counter of a known type; a function opens a new scope
        ctl.take_prev = 1'b1;
        rs_idx_nxt    = IDX_W'(fill_r);
        rs_type_nxt   = typ_r;
        rs_kind_nxt   = knd_r;
        rs_scope_nxt  = scope_r;
        rs_addr_nxt   = base_addr;
        fill_nxt      = fill_r + FILL_W'(1);
        if (typ_r < TYPE_UNKNOWN_MIN) begin
          mem_we           = 1'b1;
          sv_nxt[scope_r]  = 1'b1;
        end else begin
          rs_status_nxt = ST_BAD_TYPE;
        end
        if (knd_r == KIND_FUNCTION) begin
          scope_nxt                   = scope_r + SCOPE_W'(1);
          sv_nxt[scope_r + SCOPE_W'(1)] = 1'b0;
        end
        state_nxt = S_OUT;
      end
      S_LOOK: begin
        // Turn the ring one place; cell 0 shows entries newest first
        ctl.take_next = 1'b1;
        if (!found_r && FILL_W'(cnt_r) < fill_r &&
            cell_q[0][NM_LO +: NAME_W] == key_r) begin
          found_nxt     = 1'b1;
          rs_status_nxt = ST_OK;
          rs_idx_nxt    = walk_idx;
          rs_type_nxt   = cell_q[0][TY_LO +: TYPE_W];
          rs_kind_nxt   = cell_q[0][KD_LO +: KIND_W];
          rs_scope_nxt  = top_scope;
          rs_addr_nxt   = cell_q[0][ADDR_W-1:0];
        end
        if (cnt_r == IDX_W'(TABLE_DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_DEL: begin
        if (fill_r != '0 && top_scope == scope_r) begin
          ctl.take_next = 1'b1;
          fill_nxt      = fill_r - FILL_W'(1);
        end else begin
          scope_nxt = (fill_r != '0) ? top_scope : '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      scope_r     <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      sv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      scope_r <= scope_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
      sv_r    <= sv_nxt;
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_tdata[63:0];
      typ_r <= in_tdata[67:64];
      knd_r <= in_tdata[69:68];
    end
    rs_status_r <= rs_status_nxt;
    rs_idx_r    <= rs_idx_nxt;
    rs_type_r   <= rs_type_nxt;
    rs_kind_r   <= rs_kind_nxt;
    rs_scope_r  <= rs_scope_nxt;
    rs_addr_r   <= rs_addr_nxt;
    if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_user_r <= rs_status_r;
      out_data_r <= {1'b0, 6'(scope_r), 8'(fill_r), rs_addr_r, 6'(rs_scope_r),
                     rs_kind_r, rs_type_r, 7'(rs_idx_r)};
    end
  end

  // Scope counter memory: registered read at the current scope
  always_ff @(posedge clk) begin
    rd_r <= addr_mem[scope_r];
    rv_r <= sv_r[scope_r];
    if (mem_we) begin
      addr_mem[scope_r] <= mem_wdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_empty_scope0: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && fill_r == '0) |-> scope_r == '0)
    else $error("empty table outside scope 0");

  a_walk_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOOK) |-> cnt_r == '0)
    else $error("ring walk counter left running");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD) |=> fill_r == $past(fill_r) + FILL_W'(1))
    else $error("add did not push one entry");

endmodule
`default_nettype wire

// ----- rtl/core/ssym_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ssym_cell: one entry of the symbol stack
// Hold, take the word from the cell above or from the cell below.
// ---------------------------------------------------------------------------
module ssym_cell #(
  parameter int ENTRY_W = 90
) (
  input  wire                      clk,
  input  wire  ssym_pkg::cell_ctl_t ctl,
  input  wire  [ENTRY_W-1:0]       prev_i,
  input  wire  [ENTRY_W-1:0]       next_i,
  output logic [ENTRY_W-1:0]       q_o
);
  import ssym_pkg::*;

  logic [ENTRY_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (ctl.take_prev) begin
      q_r <= prev_i;
    end else if (ctl.take_next) begin
      q_r <= next_i;
    end
  end

  assign q_o = q_r;

endmodule
`default_nettype wire

// ----- dv/scoped_symbol_table_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scoped_symbol_table_tb: self-checking bench for the scoped symbol table
// Streams add, lookup, delete and unused-action words through the block, predicts every
// result word from a local copy of the table, and compares field by field
// under several sender and receiver idling phases.
// ---------------------------------------------------------------------------
module scoped_symbol_table_tb;
  import ssym_pkg::*;

  localparam int DEPTH  = 128;
  localparam int SCOPES = 64;
  localparam int ACT_NONE = 3;  // unused action code, ignored by the block
  localparam int HOLD_CYCLES = 2000;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] name_key;
    logic [3:0]  type_code;
    logic [1:0]  kind_code;
  } cmd_t;

  // Highest field first, so that {out_tuser, out_tdata[46:0]} maps straight on
  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  scope;
    logic [7:0]  count;
    logic [13:0] eaddr;
    logic [5:0]  escope;
    logic [1:0]  ekind;
    logic [3:0]  etype;
    logic [6:0]  idx;
  } reply_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  wire         in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  wire         out_tvalid;
  logic        out_tready = 0;
  wire  [47:0] out_tdata;
  wire  [2:0]  out_tuser;

  scoped_symbol_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #4 clk = ~clk;

  // Local copy of the table
  logic [63:0] tab_name [DEPTH];
  logic [3:0]  tab_type [DEPTH];
  logic [1:0]  tab_kind [DEPTH];
  logic [5:0]  tab_scope[DEPTH];
  logic [13:0] tab_addr [DEPTH];
  int          fill;
  int          level;
  int          next_addr[SCOPES];

  cmd_t   pending_cmds[$];
  reply_t awaited_replies[$];
  int     errors = 0;
  int     send_idle_pct = 0;   // chance of the sender idling, per cent
  int     recv_stall_pct = 0;  // chance of the receiver stalling, per cent
  bit     hold_start = 0;      // ask for a long receiver hold-off
  int     hold_cnt = 0;        // cycles held off so far
  wire    recv_hold = hold_start && (hold_cnt < HOLD_CYCLES);
  logic [63:0] used_names[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic reply_t entry_reply(input logic [2:0] st, input int i);
    reply_t r;
    r = '0;
    r.status = st;
    if (i >= 0) begin
      r.idx = i[6:0];
      r.etype = tab_type[i];
      r.ekind = tab_kind[i];
      r.escope = tab_scope[i];
      r.eaddr = tab_addr[i];
    end
    r.count = fill[7:0];
    r.scope = level[5:0];
    return r;
  endfunction

  // Work out the reply to one accepted word and advance the local table
  function automatic reply_t predict_reply(input cmd_t c);
    int i;
    int nx;
    logic [2:0] st;
    i = -1;
    st = ST_OK;
    case (c.action)
      ACT_ADD: begin
        if (fill >= DEPTH) begin
          st = ST_FULL;
        end else if (c.kind_code == KIND_FUNCTION && level + 1 >= SCOPES) begin
          st = ST_SCOPE_OVF;
        end else begin
          i = fill;
          tab_name[i] = c.name_key;
          tab_type[i] = c.type_code;
          tab_kind[i] = c.kind_code;
          tab_scope[i] = level[5:0];
          tab_addr[i] = next_addr[level][13:0];
          if (c.type_code < TYPE_UNKNOWN_MIN) begin
            case (c.type_code)
              4'd0, 4'd7: nx = 1;
              4'd1, 4'd2, 4'd3: nx = 4;
              4'd5: nx = 80;
              4'd6: nx = 2;
              default: nx = 0;
            endcase
            nx = next_addr[level] + nx;
            next_addr[level] = nx > 16383 ? 16383 : nx;
          end else begin
            st = ST_BAD_TYPE;
          end
          if (c.kind_code == KIND_FUNCTION) begin
            level++;
            next_addr[level] = 0;
          end
          fill++;
        end
      end
      ACT_LOOKUP: begin
        for (int k = fill - 1; k >= 0 && i < 0; k--)
          if (tab_name[k] == c.name_key) i = k;
        st = i >= 0 ? ST_OK : ST_NOT_FOUND;
      end
      ACT_DELETE: begin
        if (fill == 0) begin
          st = ST_EMPTY;
        end else begin
          while (fill > 0 && tab_scope[fill-1] == level) fill--;
          level = fill > 0 ? tab_scope[fill-1] : 0;
        end
      end
      default: ;
    endcase
    return entry_reply(st, i);
  endfunction

  // Driver: offer the oldest pending word; hold it until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid && in_tready) void'(pending_cmds.pop_front());
      if (pending_cmds.size() > (in_tvalid && in_tready ? 1 : 0) - (in_tvalid && in_tready ? 1 : 0)
          && pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= {2'b00, pending_cmds[0].kind_code, pending_cmds[0].type_code,
                     pending_cmds[0].name_key};
        in_tuser <= pending_cmds[0].action;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Predict on acceptance, in the same order as the block takes words
  always @(posedge clk) begin
    cmd_t c;
    if (rst_n && in_tvalid && in_tready) begin
      c.action = in_tuser;
      c.name_key = in_tdata[63:0];
      c.type_code = in_tdata[67:64];
      c.kind_code = in_tdata[69:68];
      awaited_replies.push_back(predict_reply(c));
    end
  end

  // Count the long receiver hold-off
  always @(posedge clk) begin
    if (!hold_start) hold_cnt <= 0;
    else if (hold_cnt < HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
  end

  // Monitor: stall at random, compare each taken result word
  always @(posedge clk) begin
    reply_t w;
    reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[46:0]};
      if (awaited_replies.size() == 0) begin
        report("unexpected word", got[31:0], 0);
      end else begin
        w = awaited_replies.pop_front();
        if (got.status != w.status) report("status", 32'(got.status), 32'(w.status));
        if (got.idx != w.idx) report("entry_index", 32'(got.idx), 32'(w.idx));
        if (got.etype != w.etype) report("entry_type", 32'(got.etype), 32'(w.etype));
        if (got.ekind != w.ekind) report("entry_kind", 32'(got.ekind), 32'(w.ekind));
        if (got.escope != w.escope) report("entry_scope", 32'(got.escope), 32'(w.escope));
        if (got.eaddr != w.eaddr) report("entry_address", 32'(got.eaddr), 32'(w.eaddr));
        if (got.count != w.count) report("entry_count", 32'(got.count), 32'(w.count));
        if (got.scope != w.scope) report("scope_now", 32'(got.scope), 32'(w.scope));
      end
    end
    out_tready <= rst_n && !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [63:0] pick_name();
    if (used_names.size() > 0 && $urandom_range(2) != 0)
      return used_names[$urandom_range(used_names.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic queue_cmd(input int act, input logic [63:0] nm, input int ty, input int kd);
    cmd_t c;
    c.action = act[1:0];
    c.name_key = nm;
    c.type_code = ty[3:0];
    c.kind_code = kd[1:0];
    pending_cmds.push_back(c);
    if (used_names.size() < 40) used_names.push_back(nm);
  endtask

  // Mostly well-formed programmes: functions with locals, lookups, scope exits
  task automatic queue_random(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 45)
        queue_cmd(ACT_ADD, pick_name(), $urandom_range(99) < 8 ? $urandom_range(15)
                  : $urandom_range(7), $urandom_range(99) < 20 ? 1 : $urandom_range(3));
      else if (r < 80)
        queue_cmd(ACT_LOOKUP, pick_name(), $urandom_range(15), $urandom_range(3));
      else if (r < 97)
        queue_cmd(ACT_DELETE, {$urandom, $urandom}, $urandom_range(15), $urandom_range(3));
      else
        queue_cmd(ACT_NONE, {$urandom, $urandom}, $urandom_range(15), $urandom_range(3));
    end
  endtask

  // Wait until the block has drained, then allow for a trailing delete walk
  task automatic drain();
    wait (pending_cmds.size() == 0 && !in_tvalid && awaited_replies.size() == 0);
    repeat (DEPTH + 10) @(posedge clk);
  endtask

  initial begin
    for (int s = 0; s < SCOPES; s++) next_addr[s] = 0;
    fill = 0;
    level = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table cases, every known type and kind, name extremes
    queue_cmd(ACT_DELETE, 64'h0, 0, 0);
    queue_cmd(ACT_LOOKUP, 64'h0, 0, 0);
    queue_cmd(ACT_ADD, 64'h0, 0, 0);
    queue_cmd(ACT_ADD, '1, 15, 3);
    for (int t = 1; t < 9; t++) queue_cmd(ACT_ADD, 64'h4100 + t, t, 2);
    queue_cmd(ACT_ADD, 64'h46554E, 1, 1);
    queue_cmd(ACT_ADD, 64'h42, 5, 0);
    queue_cmd(ACT_ADD, 64'h46554E, 8, 1);
    queue_cmd(ACT_LOOKUP, 64'h46554E, 0, 0);
    queue_cmd(ACT_LOOKUP, '1, 0, 0);
    queue_cmd(ACT_LOOKUP, 64'hAAAA_5555_AAAA_5555, 0, 0);
    queue_cmd(ACT_NONE, 64'h5555_AAAA_5555_AAAA, 7, 1);
    queue_cmd(ACT_DELETE, 64'h0, 0, 0);
    queue_cmd(ACT_DELETE, 64'h0, 0, 0);
    queue_cmd(ACT_DELETE, 64'h0, 0, 0);
    queue_cmd(ACT_DELETE, 64'h0, 0, 0);
    drain();

    // Scope overflow: nest functions past the scope limit, then unwind
    for (int k = 0; k < SCOPES + 2; k++) queue_cmd(ACT_ADD, 64'h1000 + k, 0, 1);
    queue_cmd(ACT_LOOKUP, 64'h1000, 0, 0);
    repeat (4) queue_cmd(ACT_DELETE, 0, 0, 0);
    drain();

    // Empty the table so that the strings below land in scope 0
    repeat (SCOPES + 6) queue_cmd(ACT_DELETE, 0, 0, 0);
    // Table full: strings until the table is full
    for (int k = 0; k < DEPTH + 3; k++) queue_cmd(ACT_ADD, 64'h2000 + k, 5, 0);
    queue_cmd(ACT_LOOKUP, 64'h2000, 0, 0);
    queue_cmd(ACT_DELETE, 0, 0, 0);
    // Address saturation: scope 0 keeps its counter, more strings take it to the top
    for (int k = 0; k < 80; k++) queue_cmd(ACT_ADD, 64'h3000 + k, 5, 0);
    queue_cmd(ACT_LOOKUP, 64'h3000, 0, 0);
    queue_cmd(ACT_DELETE, 0, 0, 0);
    drain();

    // Long receiver hold-off while the sender keeps offering
    hold_start = 1'b1;
    queue_random(30);
    wait (hold_cnt == HOLD_CYCLES);
    hold_start = 1'b0;
    drain();

    // Random phases: none, sender idle, receiver stall, both
    queue_random(100);
    drain();
    send_idle_pct = 88;
    queue_random(100);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 88;
    queue_random(100);
    drain();
    send_idle_pct = 25;
    recv_stall_pct = 25;
    queue_random(91);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
